// ----- design/lagr_pkg.sv -----
// Shared types and constants for the Lagrange interpolator.
package lagr_pkg;
  localparam int MaxPoints = 16;
  localparam int IdxW = $clog2(MaxPoints);
  localparam int NumW = 5;
  localparam int DataW = 32;
  localparam int ProdW = 64;
  localparam int DenW = 33;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  typedef struct packed {
    logic clear;
    logic load_i;
    logic load_j;
    logic mul_start;
    logic div_start;
    logic term_done;
    logic sum_done;
    logic dup_set;
  } lagr_cmd_t;

  typedef struct packed {
    logic div_done;
    logic x_equal;
  } lagr_sts_t;
endpackage

// ----- design/lagr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module lagr_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- design/lagr_div.sv -----
// Radix-2 restoring signed divider, 64 by 33 bits, truncating toward zero.
module lagr_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [lagr_pkg::ProdW-1:0] dividend,
  input  logic signed [lagr_pkg::DenW-1:0]  divisor,
  output logic                              done,
  output logic signed [lagr_pkg::ProdW-1:0] quotient
);
  import lagr_pkg::*;

  logic [ProdW-1:0] num;
  logic [ProdW-1:0] quo;
  logic [DenW-1:0] den;
  logic [DenW:0] rem;
  logic [6:0] cnt;
  logic neg;
  logic busy;
  logic [DenW:0] shifted;
  logic [DenW:0] diff;

  assign shifted = {rem[DenW-1:0], num[ProdW-1]};
  assign diff = shifted - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= 7'(ProdW);
        num <= dividend[ProdW-1] ? ProdW'(-dividend) : dividend;
        den <= divisor[DenW-1] ? DenW'(-divisor) : divisor;
        neg <= dividend[ProdW-1] ^ divisor[DenW-1];
        rem <= '0;
        quo <= '0;
      end else if (busy) begin
        num <= {num[ProdW-2:0], 1'b0};
        if (!diff[DenW]) begin
          rem <= diff;
          quo <= {quo[ProdW-2:0], 1'b1};
        end else begin
          rem <= shifted;
          quo <= {quo[ProdW-2:0], 1'b0};
        end
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = neg ? ProdW'(-quo) : quo;
endmodule

// ----- design/lagr_datapath.sv -----
// Datapath: point stores, multiplier, shared divider, term and sum registers.
module lagr_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              load_we,
  input  logic [lagr_pkg::IdxW-1:0]         load_idx,
  input  logic signed [lagr_pkg::DataW-1:0] load_x,
  input  logic signed [lagr_pkg::DataW-1:0] load_y,
  input  logic signed [lagr_pkg::DataW-1:0] query,
  input  logic [lagr_pkg::IdxW-1:0]         raddr,
  input  lagr_pkg::lagr_cmd_t               cmd,
  output lagr_pkg::lagr_sts_t               sts,
  output logic signed [lagr_pkg::DataW-1:0] sum,
  output logic                              ovf
);
  import lagr_pkg::*;

  localparam logic signed [ProdW-1:0] SMax = ProdW'(64'sd2147483647);
  localparam logic signed [ProdW-1:0] SMin = -ProdW'(64'sd2147483648);

  logic signed [DataW-1:0] xr;
  logic signed [DataW-1:0] yr;
  logic signed [DataW-1:0] xi;
  logic signed [DataW-1:0] xj;
  logic signed [DataW-1:0] term;
  logic signed [DenW-1:0] qdiff;
  logic signed [ProdW-1:0] prod;
  logic signed [ProdW-1:0] quo;
  logic signed [ProdW-1:0] total;
  logic div_done;

  lagr_ram #(.Width(DataW), .Depth(MaxPoints)) u_xram (
    .clk(clk), .we(load_we), .waddr(load_idx), .wdata(load_x), .raddr(raddr), .rdata(xr)
  );
  lagr_ram #(.Width(DataW), .Depth(MaxPoints)) u_yram (
    .clk(clk), .we(load_we), .waddr(load_idx), .wdata(load_y), .raddr(raddr), .rdata(yr)
  );

  lagr_div u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start),
    .dividend(prod), .divisor(DenW'(xi) - DenW'(xj)),
    .done(div_done), .quotient(quo)
  );

  assign total = ProdW'(sum) + ProdW'(term);
  assign qdiff = DenW'(query) - DenW'(xj);

  always_ff @(posedge clk) begin
    if (rst) begin
      ovf <= 1'b0;
      sum <= '0;
    end else begin
      if (cmd.load_i) begin
        xi <= xr;
        term <= yr;
      end
      if (cmd.load_j) begin
        xj <= xr;
      end
      if (cmd.mul_start) begin
        prod <= ProdW'(term) * ProdW'(qdiff);
      end
      if (cmd.term_done) begin
        if (quo > SMax) begin
          term <= SMax[DataW-1:0];
          ovf <= 1'b1;
        end else if (quo < SMin) begin
          term <= SMin[DataW-1:0];
          ovf <= 1'b1;
        end else begin
          term <= quo[DataW-1:0];
        end
      end
      if (cmd.sum_done) begin
        if (total > SMax) begin
          sum <= SMax[DataW-1:0];
          ovf <= 1'b1;
        end else if (total < SMin) begin
          sum <= SMin[DataW-1:0];
          ovf <= 1'b1;
        end else begin
          sum <= total[DataW-1:0];
        end
      end
      if (cmd.clear || cmd.dup_set) begin
        sum <= '0;
        ovf <= 1'b0;
      end
    end
  end

  assign sts.div_done = div_done;
  assign sts.x_equal = (xi == xj);
endmodule

// ----- design/lagr_ctrl.sv -----
// Controller: sequences duplicate scan, then the term product and sum loops.
module lagr_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      go,
  input  logic [lagr_pkg::NumW-1:0] num_points,
  input  lagr_pkg::lagr_sts_t       sts,
  output lagr_pkg::lagr_cmd_t       cmd,
  output logic [lagr_pkg::IdxW-1:0] raddr,
  output logic                      busy,
  output logic                      finish,
  output logic                      dup
);
  import lagr_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DRI = 4'd1;
  localparam logic [3:0] S_DLI = 4'd2;
  localparam logic [3:0] S_DRJ = 4'd3;
  localparam logic [3:0] S_DLJ = 4'd4;
  localparam logic [3:0] S_DCMP = 4'd5;
  localparam logic [3:0] S_RI = 4'd6;
  localparam logic [3:0] S_LI = 4'd7;
  localparam logic [3:0] S_RJ = 4'd8;
  localparam logic [3:0] S_LJ = 4'd9;
  localparam logic [3:0] S_MUL = 4'd10;
  localparam logic [3:0] S_DIV = 4'd11;
  localparam logic [3:0] S_WAIT = 4'd12;
  localparam logic [3:0] S_SUM = 4'd13;
  localparam logic [3:0] S_DONE = 4'd14;

  logic [3:0] state;
  logic [3:0] state_next;
  logic [NumW-1:0] n;
  logic [NumW-1:0] i;
  logic [NumW-1:0] j;
  logic [NumW-1:0] ni;

  assign ni = (num_points > NumW'(MaxPoints)) ? NumW'(MaxPoints) : num_points;

  always_comb begin
    cmd = '0;
    raddr = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (go) begin
          state_next = (ni == '0) ? S_DONE : S_DRI;
          cmd.clear = 1'b1;
        end
      end
      S_DRI: begin
        raddr = i[IdxW-1:0];
        state_next = S_DLI;
      end
      S_DLI: begin
        cmd.load_i = 1'b1;
        state_next = (j >= n) ? S_RI : S_DRJ;
      end
      S_DRJ: begin
        raddr = j[IdxW-1:0];
        state_next = S_DLJ;
      end
      S_DLJ: begin
        cmd.load_j = 1'b1;
        state_next = S_DCMP;
      end
      S_DCMP: begin
        if (sts.x_equal) begin
          cmd.dup_set = 1'b1;
          state_next = S_DONE;
        end else if (j + 1'b1 < n) begin
          state_next = S_DRJ;
        end else begin
          state_next = S_DRI;
        end
      end
      S_RI: begin
        raddr = i[IdxW-1:0];
        state_next = S_LI;
      end
      S_LI: begin
        cmd.load_i = 1'b1;
        state_next = S_RJ;
      end
      S_RJ: begin
        raddr = j[IdxW-1:0];
        if (j >= n) begin
          state_next = S_SUM;
        end else if (j == i) begin
          state_next = S_RJ;
        end else begin
          state_next = S_LJ;
        end
      end
      S_LJ: begin
        cmd.load_j = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul_start = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_start = 1'b1;
        state_next = S_WAIT;
      end
      S_WAIT: begin
        if (sts.div_done) begin
          cmd.term_done = 1'b1;
          state_next = S_RJ;
        end
      end
      S_SUM: begin
        cmd.sum_done = 1'b1;
        state_next = (i + 1'b1 >= n) ? S_DONE : S_RI;
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      dup <= 1'b0;
      i <= '0;
      j <= '0;
      n <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        S_IDLE: begin
          n <= ni;
          i <= '0;
          j <= NumW'(1);
          dup <= 1'b0;
        end
        S_DLI: begin
          if (j >= n) begin
            i <= '0;
            j <= '0;
          end
        end
        S_DCMP: begin
          if (sts.x_equal) begin
            dup <= 1'b1;
          end else if (j + 1'b1 < n) begin
            j <= j + 1'b1;
          end else begin
            i <= i + 1'b1;
            j <= i + NumW'(2);
          end
        end
        S_RJ: begin
          if (j == i) begin
            j <= j + 1'b1;
          end
        end
        S_WAIT: begin
          if (sts.div_done) begin
            j <= j + 1'b1;
          end
        end
        S_SUM: begin
          i <= i + 1'b1;
          j <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  assign busy = (state != S_IDLE);
  assign finish = (state == S_DONE);

  assert property (@(posedge clk) disable iff (rst) finish |=> !busy)
    else $error("finish not followed by idle");
  assert property (@(posedge clk) disable iff (rst) cmd.div_start |=> state == S_WAIT)
    else $error("divider start without wait");
  assert property (@(posedge clk) disable iff (rst) (busy && state != S_DONE) |-> n != '0)
    else $error("evaluation with no points");
endmodule

// ----- design/lagrange_interpolator_top.sv -----
// Top level: APB register, command port, controller and datapath.
// Load: the point is written when start is taken, busy stays low. Evaluate:
// a duplicate scan, then term steps that all share the 64-step radix-2
// divider; done strobes once at the end, with value registered.
// Results cannot be stalled. Synchronous reset sets num_points to 1;
// point stores are undefined until loaded.
module lagrange_interpolator_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [2:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  input  logic                              start,
  output logic                              busy,
  input  logic                              opcode,
  input  logic [3:0]                        point_index,
  input  logic signed [lagr_pkg::DataW-1:0] point_x,
  input  logic signed [lagr_pkg::DataW-1:0] point_y,
  input  logic signed [lagr_pkg::DataW-1:0] query_x,
  output logic                              done,
  output logic signed [lagr_pkg::DataW-1:0] value,
  output logic                              duplicate_error,
  output logic                              overflow
);
  import lagr_pkg::*;

  localparam logic [2:0] REG_NUM_POINTS = 3'd0;

  logic [NumW-1:0] num_points;
  logic signed [DataW-1:0] query;
  logic ctrl_busy;
  logic finish;
  logic dup;
  logic go;
  logic signed [DataW-1:0] sum;
  logic ovf;
  logic [IdxW-1:0] raddr;
  lagr_cmd_t cmd;
  lagr_sts_t sts;

  assign pready = 1'b1;
  assign prdata = (paddr == REG_NUM_POINTS) ? 32'(num_points) : '0;
  assign go = start && !busy && (opcode == OP_EVAL);

  always_ff @(posedge clk) begin
    if (rst) begin
      num_points <= NumW'(1);
      done <= 1'b0;
    end else begin
      if (psel && penable && pwrite && paddr == REG_NUM_POINTS) begin
        num_points <= pwdata[NumW-1:0];
      end
      done <= finish;
    end
    if (go) begin
      query <= query_x;
    end
    if (finish) begin
      value <= sum;
      duplicate_error <= dup;
      overflow <= ovf;
    end
  end

  assign busy = ctrl_busy || done;

  lagr_ctrl u_ctrl (
    .clk(clk), .rst(rst), .go(go), .num_points(num_points), .sts(sts),
    .cmd(cmd), .raddr(raddr), .busy(ctrl_busy), .finish(finish), .dup(dup)
  );

  lagr_datapath u_dp (
    .clk(clk), .rst(rst),
    .load_we(start && !busy && opcode == OP_LOAD),
    .load_idx(point_index), .load_x(point_x), .load_y(point_y),
    .query(query), .raddr(raddr), .cmd(cmd), .sts(sts), .sum(sum), .ovf(ovf)
  );
endmodule

// ----- test/tb_top.sv -----
// Testbench for the Lagrange interpolator: point loads and evaluations checked against a predictor.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import lagr_pkg::*;

  typedef struct packed {
    logic op;
    logic [3:0] idx;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] qx;
  } word_t;

  typedef struct packed {
    logic signed [31:0] val;
    logic dup;
    logic ovf;
  } interp_t;

  localparam longint S32Max = 64'sd2147483647;
  localparam longint S32Min = -64'sd2147483648;
  localparam int WatchLimit = 200000;

  logic clk = 1'b0, rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic start = 1'b0, busy, done;
  word_t cur = '0;
  logic signed [31:0] value;
  logic duplicate_error, overflow;

  word_t pending_words[$];
  interp_t expected_interp[$];
  longint xs[MaxPoints], ys[MaxPoints];
  int unsigned num_cfg = 1;
  int max_gap = 0, gap_left = 0, fails = 0, watch = 0;
  int n_load = 0, n_eval = 0, n_dup = 0, n_ovf = 0;
  bit have = 0, took = 0;

  lagrange_interpolator_top u_top (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .start(start), .busy(busy), .opcode(cur.op), .point_index(cur.idx),
    .point_x(cur.px), .point_y(cur.py), .query_x(cur.qx), .done(done),
    .value(value), .duplicate_error(duplicate_error), .overflow(overflow)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic longint clip32(input longint v, inout logic f);
    if (v > S32Max) begin
      f = 1'b1;
      return S32Max;
    end
    if (v < S32Min) begin
      f = 1'b1;
      return S32Min;
    end
    return v;
  endfunction

  function automatic interp_t interpolate(input longint q);
    interp_t r;
    int n;
    longint term, acc;
    logic f;
    r = '0;
    f = 1'b0;
    acc = 0;
    n = (num_cfg > MaxPoints) ? MaxPoints : num_cfg;
    for (int i = 0; i < n; i++)
      for (int j = i + 1; j < n; j++)
        if (xs[i] == xs[j]) r.dup = 1'b1;
    if (!r.dup) begin
      for (int i = 0; i < n; i++) begin
        term = ys[i];
        for (int j = 0; j < n; j++)
          if (j != i) term = clip32((term * (q - xs[j])) / (xs[i] - xs[j]), f);
        acc = clip32(acc + term, f);
      end
      r.val = acc[31:0];
      r.ovf = f;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    interp_t e;
    bit act;
    if (!rst) begin
      act = 1'b0;
      if (start && !busy) begin
        act = 1'b1;
        took = 1;
        if (cur.op == OP_LOAD) begin
          xs[cur.idx] = longint'(cur.px);
          ys[cur.idx] = longint'(cur.py);
          n_load++;
        end else begin
          e = interpolate(longint'(cur.qx));
          expected_interp.push_back(e);
          n_eval++;
        end
      end
      if (psel && penable) act = 1'b1;
      if (done) begin
        act = 1'b1;
        if (expected_interp.size() == 0) begin
          $error("unexpected result word value=%0d", value);
          fails++;
        end else begin
          e = expected_interp.pop_front();
          if (e.dup) n_dup++;
          if (e.ovf) n_ovf++;
          if (value !== e.val) begin
            $error("value exp=%0d got=%0d", e.val, value);
            fails++;
          end
          if (duplicate_error !== e.dup) begin
            $error("duplicate_error exp=%0b got=%0b", e.dup, duplicate_error);
            fails++;
          end
          if (overflow !== e.ovf) begin
            $error("overflow exp=%0b got=%0b", e.ovf, overflow);
            fails++;
          end
        end
      end
      watch <= act ? 0 : watch + 1;
      if (watch >= WatchLimit) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    logic start_n;
    if (took) begin
      took = 0;
      have = 0;
    end
    if (!have && pending_words.size() != 0) begin
      cur <= pending_words[0];
      void'(pending_words.pop_front());
      have = 1;
      gap_left = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
    end
    start_n = 1'b0;
    if (have) begin
      if (gap_left == 0) start_n = 1'b1;
      else gap_left--;
    end
    start <= start_n;
  end

  task automatic reg_write(input int unsigned v);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= 3'd0;
    pwdata <= v;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    num_cfg = v & 32'h1f;
  endtask

  task automatic drain();
    wait (pending_words.size() == 0 && !have && expected_interp.size() == 0);
    @(posedge clk);
    wait (!busy);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic signed [31:0] pick_val();
    case ($urandom_range(0, 9))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2, 3: return $urandom();
      default: return $signed($urandom_range(0, 32'h000fffff)) - 32'sh00080000;
    endcase
  endfunction

  task automatic push_load(input int i, input logic signed [31:0] x, input logic signed [31:0] y);
    word_t w;
    w = '0;
    w.op = OP_LOAD;
    w.idx = i[3:0];
    w.px = x;
    w.py = y;
    w.qx = $urandom();
    pending_words.push_back(w);
  endtask

  task automatic push_eval(input logic signed [31:0] q);
    word_t w;
    w = '0;
    w.op = OP_EVAL;
    w.idx = 4'($urandom());
    w.px = $urandom();
    w.py = $urandom();
    w.qx = q;
    pending_words.push_back(w);
  endtask

  initial begin
    int total, n, batch, big;
    logic signed [31:0] xv[MaxPoints];
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < MaxPoints; i++)
      push_load(i, i * 32'sh10000, (i == 1) ? 32'sh80000000 : 32'sh7fffffff - i);
    push_eval(32'sh0);
    push_eval(32'sh7fffffff);
    push_eval(32'sh80000000);
    drain();
    reg_write(2);
    push_load(0, 32'sh0, 32'sh7fffffff);
    push_load(1, 32'sh1, 32'sh80000000);
    push_eval(32'sh7fffffff);
    push_eval(32'sh80000000);
    push_load(1, 32'sh0, 32'sh1);
    push_eval(32'sh10000);
    drain();
    reg_write(0);
    push_eval(32'sh12345);
    drain();
    reg_write(31);
    push_load(1, 32'sh10000, 32'sh20000);
    push_eval(32'sh8000);
    drain();
    reg_write(17);
    push_eval(32'sh7fffffff);
    drain();

    total = 0;
    big = 0;
    while (total < 850) begin
      case ($urandom_range(0, 19))
        0: n = 0;
        1: n = (big < 6) ? $urandom_range(11, 31) : 3;
        2, 3, 4: n = $urandom_range(6, 10);
        default: n = $urandom_range(1, 5);
      endcase
      if (n > 10) big++;
      reg_write(n);
      max_gap = ($urandom_range(0, 2) == 0) ? 0 : 15;
      batch = (n > 10) ? 2 : $urandom_range(15, 35);
      for (int k = 0; k < batch; k++) begin
        if (n > 10 || $urandom_range(0, 9) < 3) begin
          push_eval(pick_val());
        end else begin
          int i;
          i = $urandom_range(0, 15);
          xv[i] = pick_val();
          if ($urandom_range(0, 15) == 0) xv[i] = xv[$urandom_range(0, 15)];
          if (xv[i] === 'x) xv[i] = $urandom();
          push_load(i, xv[i], pick_val());
        end
        total++;
      end
      drain();
    end

    drain();
    repeat (50) @(posedge clk);
    $display("covered %0d loads and %0d evaluations across many point counts", n_load, n_eval);
    $display("results with duplicate x: %0d, with saturation: %0d", n_dup, n_ovf);
    if (fails == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule
